// ===== src/fdbb_pkg.sv =====
// ----------------------------------------------------------------------------
// fdbb_pkg: shared types and constants of the frame difference box finder
// Field widths of the stream items, register indexes and the result record.
// ----------------------------------------------------------------------------
package fdbb_pkg;

  localparam int PIX_W    = 32;   // pixel word on the ports
  localparam int POS_W    = 12;   // box_left / box_top
  localparam int SIZE_W   = 13;   // box_width / box_height and size registers
  localparam int CFG_IDX_W = 1;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 88;

  localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = 13'd1920;
  localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = 13'd1080;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [SIZE_W-1:0] box_height;
    logic [SIZE_W-1:0] box_width;
    logic [POS_W-1:0]  box_top;
    logic [POS_W-1:0]  box_left;
    logic              any_change;
    logic              frame_done;
    logic [PIX_W-1:0]  diff_pixel;
  } result_t;

  // handshake between the input register and the rest of the pipeline
  typedef struct packed {
    logic advance;  // output side can take a new item this cycle
    logic fire;     // the held item moves into the result register
  } pipe_ctrl_t;

endpackage

// ===== src/fdbb_in_reg.sv =====
// ----------------------------------------------------------------------------
// fdbb_in_reg: input register
// Holds one accepted pixel pair until the result stage takes it.
// ----------------------------------------------------------------------------
module fdbb_in_reg
  import fdbb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [IN_TDATA_W-1:0] in_data,
  input  logic                  advance,
  output logic                  held_valid,
  output logic [PIX_W-1:0]      held_ref,
  output logic [PIX_W-1:0]      held_cur
);

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_ref <= in_data[PIX_W-1:0];
      held_cur <= in_data[2*PIX_W-1:PIX_W];
    end
  end

endmodule

// ===== src/fdbb_cfg.sv =====
// ----------------------------------------------------------------------------
// fdbb_cfg: frame size registers
// Write port for the two size registers; zero reads as one, large values
// saturate to the largest supported dimension.
// ----------------------------------------------------------------------------
module fdbb_cfg
  import fdbb_pkg::*;
#(
  parameter int MAX_DIMENSION = 4096,
  parameter int SW = 13
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  output logic [SW-1:0]        eff_width,
  output logic [SW-1:0]        eff_height
);

  logic [SIZE_W-1:0] frame_width;
  logic [SIZE_W-1:0] frame_height;
  logic [SW-1:0]     width_ext;
  logic [SW-1:0]     height_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign width_ext  = SW'(frame_width);
  assign height_ext = SW'(frame_height);

  always_comb begin
    priority if (frame_width == '0) begin
      eff_width = SW'(1);
    end else if (width_ext > SW'(MAX_DIMENSION)) begin
      eff_width = SW'(MAX_DIMENSION);
    end else begin
      eff_width = width_ext;
    end
  end

  always_comb begin
    priority if (frame_height == '0) begin
      eff_height = SW'(1);
    end else if (height_ext > SW'(MAX_DIMENSION)) begin
      eff_height = SW'(MAX_DIMENSION);
    end else begin
      eff_height = height_ext;
    end
  end

endmodule

// ===== src/fdbb_track.sv =====
// ----------------------------------------------------------------------------
// fdbb_track: raster position and changed-pixel box
// Compares the held pair, updates column/row and the min/max trackers, and
// forms the result item, including the box on the last pixel of a frame.
// ----------------------------------------------------------------------------
module fdbb_track
  import fdbb_pkg::*;
#(
  parameter int MAX_DIMENSION = 4096,
  parameter int PIXEL_BITS = 32,
  parameter int SW = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  pipe_ctrl_t       ctrl,
  input  logic [PIX_W-1:0] held_ref,
  input  logic [PIX_W-1:0] held_cur,
  input  logic [SW-1:0]    eff_width,
  input  logic [SW-1:0]    eff_height,
  output result_t          result
);

  localparam int CW  = $clog2(MAX_DIMENSION);
  localparam int CMP = (PIXEL_BITS >= PIX_W) ? PIX_W : PIXEL_BITS;
  localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((64'd1 << CMP) - 64'd1);

  logic [CW-1:0] column_count, row_count;
  logic [CW-1:0] min_column, min_row, max_column, max_row;
  logic          change_seen;

  logic [CW-1:0] min_column_next, min_row_next, max_column_next, max_row_next;
  logic          change_seen_next;
  logic [PIX_W-1:0] ref_m, cur_m;
  logic          differs, first, row_end, frame_end;
  logic [SW-1:0] span_w, span_h;

  assign ref_m   = held_ref & PIX_MASK;
  assign cur_m   = held_cur & PIX_MASK;
  assign differs = (ref_m != cur_m);
  assign first   = differs && !change_seen;

  // "at or beyond the last" so a size shrunk mid-frame still ends the row
  assign row_end   = (SW'(column_count) + SW'(1)) >= eff_width;
  assign frame_end = row_end && ((SW'(row_count) + SW'(1)) >= eff_height);

  always_comb begin
    min_column_next = min_column;
    max_column_next = max_column;
    min_row_next    = min_row;
    max_row_next    = max_row;
    if (first) begin
      min_column_next = column_count;
      max_column_next = column_count;
      min_row_next    = row_count;
      max_row_next    = row_count;
    end else if (differs) begin
      if (column_count < min_column) min_column_next = column_count;
      if (column_count > max_column) max_column_next = column_count;
      if (row_count < min_row)       min_row_next    = row_count;
      if (row_count > max_row)       max_row_next    = row_count;
    end
  end

  assign change_seen_next = change_seen || differs;
  assign span_w = SW'(max_column_next) - SW'(min_column_next) + SW'(1);
  assign span_h = SW'(max_row_next) - SW'(min_row_next) + SW'(1);

  always_comb begin
    result            = '0;
    result.diff_pixel = differs ? cur_m : '0;
    result.frame_done = frame_end;
    if (frame_end && change_seen_next) begin
      result.any_change = 1'b1;
      result.box_left   = POS_W'(min_column_next);
      result.box_top    = POS_W'(min_row_next);
      result.box_width  = SIZE_W'(span_w);
      result.box_height = SIZE_W'(span_h);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      min_column   <= '1;
      min_row      <= '1;
      max_column   <= '0;
      max_row      <= '0;
      change_seen  <= 1'b0;
    end else if (ctrl.fire) begin
      if (frame_end) begin
        column_count <= '0;
        row_count    <= '0;
        min_column   <= '1;
        min_row      <= '1;
        max_column   <= '0;
        max_row      <= '0;
        change_seen  <= 1'b0;
      end else begin
        if (row_end) begin
          column_count <= '0;
          row_count    <= row_count + CW'(1);
        end else begin
          column_count <= column_count + CW'(1);
        end
        min_column  <= min_column_next;
        min_row     <= min_row_next;
        max_column  <= max_column_next;
        max_row     <= max_row_next;
        change_seen <= change_seen_next;
      end
    end
  end

endmodule

// ===== src/fdbb_out_reg.sv =====
// ----------------------------------------------------------------------------
// fdbb_out_reg: result register
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module fdbb_out_reg
  import fdbb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       held_valid,
  input  result_t    result,
  input  logic       out_ready,
  output logic       out_valid,
  output result_t    out_item,
  output pipe_ctrl_t ctrl
);

  assign ctrl.advance = !out_valid || out_ready;
  assign ctrl.fire    = held_valid && ctrl.advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.advance) begin
      out_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      out_item <= result;
    end
  end

endmodule

// ===== src/frame_diff_bounding_box.sv =====
// ----------------------------------------------------------------------------
// frame_diff_bounding_box: changed-region finder over a pixel pair stream
// Gives a diff pixel per pair and the bounding box of changed pixels per frame.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel takes one reference/current pixel pair per item in raster
//   order. Master channel gives one result item per input item: the diff
//   pixel (current word where the pair differs, zero otherwise), with tlast
//   high on the last pixel of a frame. On that item only, any_change and the
//   box (left, top, width, height) are filled in; elsewhere they are zero.
//   Path: an accepted item passes the input register, then the result
//   register, to the master side. Throughput: one item per cycle while
//   m_axis_tready is high; compare, min/max update and the width/height
//   subtract sit in the single stage between the two regs.
//   Stall: when the receiver holds tready low the result register keeps its
//   item and the input register can still take one more item, after which
//   s_axis_tready drops until the result register drains.
//   Reset (rst, synchronous): both registers empty, position at column 0 /
//   row 0, trackers cleared, frame size back to 1920 x 1080.
//   Config: cfg_wr_en writes cfg_data to register cfg_index (0 width,
//   1 height) on the edge; write only while no item is in flight. Zero
//   reads as one, values above MAX_DIMENSION saturate.
// ----------------------------------------------------------------------------
module frame_diff_bounding_box
  import fdbb_pkg::*;
#(
  parameter int MAX_DIMENSION = 4096,
  parameter int PIXEL_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  // tdata: reference_pixel [31:0], current_pixel [63:32]
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tdata: diff_pixel [31:0], any_change [32], box_left [44:33],
  //        box_top [56:45], box_width [69:57], box_height [82:70], zero pad
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast,   // frame_done
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [SIZE_W-1:0]      cfg_data
);

  // size compare width: holds the 13-bit register and MAX_DIMENSION itself
  localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
  localparam int SW    = (DIM_W > SIZE_W) ? DIM_W : SIZE_W;

  logic             held_valid;
  logic [PIX_W-1:0] held_ref, held_cur;
  logic [SW-1:0]    eff_width, eff_height;
  pipe_ctrl_t       ctrl;
  result_t          result, out_item;

  fdbb_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_data    (s_axis_tdata),
    .advance    (ctrl.advance),
    .held_valid (held_valid),
    .held_ref   (held_ref),
    .held_cur   (held_cur)
  );

  fdbb_cfg #(
    .MAX_DIMENSION (MAX_DIMENSION),
    .SW            (SW)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .eff_width  (eff_width),
    .eff_height (eff_height)
  );

  fdbb_track #(
    .MAX_DIMENSION (MAX_DIMENSION),
    .PIXEL_BITS    (PIXEL_BITS),
    .SW            (SW)
  ) u_track (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .held_ref   (held_ref),
    .held_cur   (held_cur),
    .eff_width  (eff_width),
    .eff_height (eff_height),
    .result     (result)
  );

  fdbb_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .result     (result),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_item   (out_item),
    .ctrl       (ctrl)
  );

  assign m_axis_tlast = out_item.frame_done;
  assign m_axis_tdata = {5'b0, out_item.box_height, out_item.box_width,
                         out_item.box_top, out_item.box_left,
                         out_item.any_change, out_item.diff_pixel};

endmodule

// ===== src/fdbb_checker.sv =====
// ----------------------------------------------------------------------------
// fdbb_checker: port-level checks
// Watches the master side for box reporting rules, stall behaviour and the state after reset.
// ----------------------------------------------------------------------------
module fdbb_checker
  import fdbb_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast
);

  // a stalled item holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result item changed while stalled");

  // box only on the last pixel of a frame
  a_box_only_at_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[82:32] == '0)
    else $error("box fields set before frame end");

  // unchanged frame reports an empty box
  a_empty_box: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast && !m_axis_tdata[32] |->
      m_axis_tdata[82:33] == '0)
    else $error("box reported for unchanged frame");

  // a changed frame has a box of at least one pixel
  a_box_nonempty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[32] |->
      m_axis_tdata[69:57] != '0 && m_axis_tdata[82:70] != '0)
    else $error("changed frame with empty box");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind frame_diff_bounding_box fdbb_checker u_fdbb_checker (.*);
